@@ sv/psd_pkg.sv @@
// shared constants and control types for the pruefer sequence decoder
package psd_pkg;

  // default vertex capacity of the tree
  localparam int MAX_VERTICES_DEF = 64;

  // fixed field widths
  localparam int CODE_W = 7;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 7;

  // saturation value of the occurrence and load counters
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // controls of the occurrence count store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } occ_ctrl_t;

endpackage

@@ sv/psd_occ_mem.sv @@
// occurrence count store: synchronous memory with valid bits and write forwarding
module psd_occ_mem #(
  parameter int MAX_VERTICES = psd_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  psd_pkg::occ_ctrl_t             ctrl,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  input  logic [psd_pkg::CNT_W-1:0]      wr_data,
  output logic [psd_pkg::CNT_W-1:0]      rd_cnt,
  output logic [MAX_VERTICES-1:0]        nonzero
);

  logic [psd_pkg::CNT_W-1:0] mem [MAX_VERTICES];
  logic [psd_pkg::CNT_W-1:0] rd_q;
  logic                      nz_q;
  logic                      fwd;
  logic [psd_pkg::CNT_W-1:0] fwd_data;

  // memory write and registered read, with a bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q     <= mem[rd_addr];
      nz_q     <= nonzero[rd_addr];
      fwd      <= ctrl.wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // one valid bit per entry: an entry not marked reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      nonzero <= '0;
    end else if (ctrl.wr_en) begin
      nonzero[wr_addr] <= (wr_data != '0);
    end
  end

  // effective count of the last read
  assign rd_cnt = fwd ? fwd_data : (nz_q ? rd_q : '0);

endmodule

@@ sv/prufer_sequence_decoder.sv @@
// Pruefer sequence decoder: loads code words one per cycle, then streams the tree's edges.
// A load word (tuser low) is taken whenever the block is idle. A decode word (tuser high) checks the loaded
// sequence and then streams seq_length edge words, one per cycle while the output is not held off,
// followed by the final word with tlast high. Each code passes through a three-step chain: code
// store read, count read and leaf search over the free-vertex vector, pipelined with forwarding
// into the count store. A malformed sequence gives one word with tuser and tlast high and zero
// labels instead. No input word is taken while a decode is running; the stores are cleared as
// it ends.
module prufer_sequence_decoder #(
  parameter int MAX_VERTICES = psd_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,   // seq_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [6:0] code_value, [7] zero
  input  logic        s_tuser,     // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // [6:0] edge_first, [13:7] edge_second, [15:14] zero
  output logic        m_tlast,     // last_edge
  output logic        m_tuser      // bad_input
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CD  = MAX_VERTICES - 2;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int CW  = psd_pkg::CODE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  // smallest set bit of a vertex vector, with a found flag on top
  function automatic logic [AW:0] find_first(input logic [MAX_VERTICES-1:0] vec);
    logic [AW:0] r;
    r = '0;
    for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
      if (vec[v]) begin
        r = {1'b1, AW'(v)};
      end
    end
    return r;
  endfunction

  state_t                     state;
  logic [psd_pkg::LEN_W-1:0]  seq_len;
  logic [psd_pkg::CNT_W-1:0]  loaded_cnt;
  logic                       err_flag;
  logic [CW-1:0]              max_code;
  logic [MAX_VERTICES-1:0]    removed;
  logic                       lb_v;
  logic [AW-1:0]              lb_addr;
  logic [psd_pkg::LEN_W-1:0]  rd_idx;
  logic                       s1_v;
  logic                       s2_v;
  logic [CW-1:0]              cs_q;
  logic [CW-1:0]              s2_code;
  logic                       out_valid;
  logic [CW-1:0]              out_first;
  logic [CW-1:0]              out_second;
  logic                       out_last;
  logic                       out_bad;

  logic [CW-1:0] code_mem [CD];

  logic [CW-1:0]             in_code;
  logic [CW-1:0]             n;
  logic                      accept;
  logic                      load_acc;
  logic                      dec_acc;
  logic                      code_ok;
  logic                      bad;
  logic                      adv;
  logic                      issue;
  logic                      s2_fire;
  logic                      fin_fire;
  logic                      err_fire;
  logic [MAX_VERTICES-1:0]   nonzero;
  logic [MAX_VERTICES-1:0]   free_vec;
  logic [MAX_VERTICES-1:0]   free_b;
  logic [AW:0]               first_a;
  logic [AW:0]               first_b;
  logic [CW-1:0]             lbl_a;
  logic [CW-1:0]             lbl_b;
  psd_pkg::occ_ctrl_t        occ_ctrl;
  logic [AW-1:0]             occ_rd_addr;
  logic [AW-1:0]             occ_wr_addr;
  logic [psd_pkg::CNT_W-1:0] occ_wr_data;
  logic [psd_pkg::CNT_W-1:0] occ_cnt;

  // handshake and sequence checks
  assign in_code  = s_tdata[CW-1:0];
  assign n        = CW'(seq_len) + CW'(2);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_acc = accept && !s_tuser;
  assign dec_acc  = accept && s_tuser;
  assign code_ok  = (in_code != '0) && (in_code <= CW'(MAX_VERTICES));
  assign bad      = err_flag || (loaded_cnt != psd_pkg::CNT_W'(seq_len)) ||
                    (n > CW'(MAX_VERTICES)) || (max_code > n);
  assign adv      = !out_valid || m_tready;
  assign issue    = (state == ST_RUN) && (rd_idx < seq_len);
  assign s2_fire  = s2_v && adv;
  assign fin_fire = (state == ST_FINAL) && adv;
  assign err_fire = (state == ST_ERR) && adv;

  // free vertices: zero count, not removed, inside the tree
  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      free_vec[v] = !nonzero[v] && !removed[v] && (CW'(v) < n);
    end
  end

  // leaf search, and the second free vertex for the final word
  always_comb begin
    first_a = find_first(free_vec);
    free_b  = free_vec;
    if (first_a[AW]) begin
      free_b[first_a[AW-1:0]] = 1'b0;
    end
    first_b = find_first(free_b);
    lbl_a   = first_a[AW] ? CW'(first_a[AW-1:0]) + CW'(1) : '0;
    lbl_b   = first_b[AW] ? CW'(first_b[AW-1:0]) + CW'(1) : '0;
  end

  // count store access: increment on load, decrement on each edge
  always_comb begin
    occ_ctrl.rd_en = (load_acc && code_ok) || (adv && s1_v);
    occ_ctrl.wr_en = lb_v || (s2_fire && (occ_cnt != '0));
    occ_ctrl.clear = fin_fire || err_fire;
    occ_rd_addr    = load_acc ? AW'(in_code - CW'(1)) : AW'(cs_q - CW'(1));
    occ_wr_addr    = lb_v ? lb_addr : AW'(s2_code - CW'(1));
    if (lb_v) begin
      occ_wr_data = (occ_cnt == psd_pkg::CNT_MAX) ? occ_cnt : occ_cnt + 1'b1;
    end else begin
      occ_wr_data = occ_cnt - 1'b1;
    end
  end

  psd_occ_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_occ (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (occ_ctrl),
    .rd_addr (occ_rd_addr),
    .wr_addr (occ_wr_addr),
    .wr_data (occ_wr_data),
    .rd_cnt  (occ_cnt),
    .nonzero (nonzero)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seq_len    <= '0;
      loaded_cnt <= '0;
      err_flag   <= 1'b0;
      max_code   <= '0;
      removed    <= '0;
      lb_v       <= 1'b0;
      rd_idx     <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        seq_len <= cfg_wdata;
      end
      lb_v <= load_acc && code_ok;
      if (load_acc) begin
        if (loaded_cnt != psd_pkg::CNT_MAX) begin
          loaded_cnt <= loaded_cnt + 1'b1;
        end
        if (!code_ok) begin
          err_flag <= 1'b1;
        end else if (in_code > max_code) begin
          max_code <= in_code;
        end
      end
      // output word valid: set by an edge, final or error word, cleared when taken
      if (s2_fire || fin_fire || err_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (dec_acc) begin
            rd_idx <= '0;
            if (bad) begin
              state <= ST_ERR;
            end else if (seq_len == '0) begin
              state <= ST_FINAL;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (issue) begin
              rd_idx <= rd_idx + 1'b1;
            end
            s1_v <= issue;
            s2_v <= s1_v;
          end
          if (s2_fire) begin
            if (first_a[AW]) begin
              removed[first_a[AW-1:0]] <= 1'b1;
            end
          end
          if (!issue && !s1_v && !s2_v) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL, ST_ERR: begin
          if (adv) begin
            loaded_cnt <= '0;
            err_flag   <= 1'b0;
            max_code   <= '0;
            removed    <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // code store and pipeline payload
  always_ff @(posedge clk) begin
    if (load_acc && (loaded_cnt < psd_pkg::CNT_W'(CD))) begin
      code_mem[loaded_cnt[CAW-1:0]] <= in_code;
    end
    if (adv && issue) begin
      cs_q <= code_mem[rd_idx[CAW-1:0]];
    end
    if (adv && s1_v) begin
      s2_code <= cs_q;
    end
    if (load_acc) begin
      lb_addr <= AW'(in_code - CW'(1));
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_first  <= lbl_a;
      out_second <= s2_code;
      out_last   <= 1'b0;
      out_bad    <= 1'b0;
    end else if (fin_fire) begin
      out_first  <= lbl_a;
      out_second <= lbl_b;
      out_last   <= 1'b1;
      out_bad    <= 1'b0;
    end else if (err_fire) begin
      out_first  <= '0;
      out_second <= '0;
      out_last   <= 1'b1;
      out_bad    <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_second, out_first};
  assign m_tlast  = out_last;
  assign m_tuser  = out_bad;

`ifndef SYNTH
  // a checked sequence always has a nonzero count for the code being consumed
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    s2_fire |-> (occ_cnt != '0))
    else $error("decode step read a zero occurrence count");

  // a checked sequence always offers a leaf
  a_leaf_found: assert property (@(posedge clk) disable iff (rst)
    s2_fire |-> first_a[AW])
    else $error("no free vertex for an edge");

  // two vertices remain at the end of a decode
  a_final_pair: assert property (@(posedge clk) disable iff (rst)
    fin_fire |-> (first_a[AW] && first_b[AW]))
    else $error("final word lacks two free vertices");

  // load increments and decode decrements never share the write port
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(lb_v && s2_v))
    else $error("load write overlaps a decode step");
`endif

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the pruefer sequence decoder: directed table then random sequences
`timescale 1ns / 1ps

module tb_top;

  localparam int NV            = psd_pkg::MAX_VERTICES_DEF;
  localparam int CODE_W        = psd_pkg::CODE_W;
  localparam int LEN_W         = psd_pkg::LEN_W;
  localparam int CNT_W         = psd_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = psd_pkg::CNT_MAX;
  localparam int CODE_SLOTS    = NV - 2;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_WORDS    = 110;

  typedef enum logic {ACT_LOAD = 1'b0, ACT_DECODE = 1'b1} action_t;
  typedef enum int {ROW_CFG, ROW_LOAD, ROW_DECODE} row_kind_t;
  typedef enum int {FLAW_NONE, FLAW_RANGE, FLAW_COUNT, FLAW_NOISE} flaw_t;

  // one result word: tree edge or the rejection word
  typedef struct packed {
    logic [CODE_W-1:0] leaf;
    logic [CODE_W-1:0] nbr;
    logic              is_last;
    logic              is_bad;
  } tree_link_t;

  typedef struct {
    row_kind_t         kind;
    logic [CODE_W-1:0] val;
    bit                typed;
    tree_link_t        want;
  } row_t;

  localparam tree_link_t REJECT_WORD = '{leaf: '0, nbr: '0, is_last: 1'b1, is_bad: 1'b0 | 1'b1};
  localparam tree_link_t TWO_VERTEX_TREE = '{leaf: 7'd1, nbr: 7'd2, is_last: 1'b1, is_bad: 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [6:0] code_value, [7] zero
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [6:0] edge_first, [13:7] edge_second, [15:14] zero
  logic        m_tlast;        // last_edge
  logic        m_tuser;        // bad_input

  prufer_sequence_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // shadow state of the decoder
  logic [CODE_W-1:0] code_mem [CODE_SLOTS];
  logic [CNT_W-1:0]  hits [NV];
  bit                gone [NV];
  logic [CNT_W-1:0]  load_cnt;
  bit                load_err;
  logic [LEN_W-1:0]  len_cfg;

  tree_link_t forecast_q[$];
  tree_link_t link_q[$];
  row_t       script[$];

  bit idle_on = 1'b0;
  int stall_left = 0;
  int quiet = 0;
  int err_cnt = 0;
  int words_sent = 0;
  int decodes_sent = 0;
  int rejects = 0;
  int results_seen = 0;
  int rand_words = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void wipe_model();
    foreach (code_mem[i]) code_mem[i] = '0;
    foreach (hits[i]) hits[i] = '0;
    foreach (gone[i]) gone[i] = 1'b0;
    load_cnt = '0;
    load_err = 1'b0;
  endfunction

  // store one code and count its vertex
  function automatic void absorb_code(input logic [CODE_W-1:0] code);
    if (load_cnt < CODE_SLOTS) code_mem[load_cnt] = code;
    if (load_cnt != CNT_MAX) load_cnt++;
    if (code == 0 || code > NV) load_err = 1'b1;
    else if (hits[code-1] != CNT_MAX) hits[code-1]++;
  endfunction

  // smallest vertex index from 'from' up that is a leaf not yet taken
  function automatic int lowest_free(input int from, input int n);
    for (int v = from; v < n; v++)
      if (hits[v] == 0 && !gone[v]) return v;
    return -1;
  endfunction

  // rebuild the tree edges from the held codes into forecast_q
  function automatic void decode_tree();
    int n;
    bit bad;
    int leaf, a, b, c;
    tree_link_t w;
    n = int'(len_cfg) + 2;
    bad = load_err || (load_cnt != {1'b0, len_cfg}) || n > NV;
    if (!bad)
      for (int i = 0; i < int'(len_cfg); i++)
        if (int'(code_mem[i]) > n) bad = 1'b1;
    if (bad) begin
      forecast_q.push_back(REJECT_WORD);
      rejects++;
    end else begin
      for (int i = 0; i < int'(len_cfg); i++) begin
        c = int'(code_mem[i]);
        leaf = lowest_free(0, n);
        if (leaf >= 0) gone[leaf] = 1'b1;
        w = '{leaf: 7'(leaf + 1), nbr: 7'(c), is_last: 1'b0, is_bad: 1'b0};
        forecast_q.push_back(w);
        if (c >= 1 && hits[c-1] > 0) hits[c-1]--;
      end
      a = lowest_free(0, n);
      b = (a >= 0) ? lowest_free(a + 1, n) : -1;
      w = '{leaf: 7'(a + 1), nbr: 7'(b + 1), is_last: 1'b1, is_bad: 1'b0};
      forecast_q.push_back(w);
    end
    wipe_model();
  endfunction

  // drive one input word and wait until it is taken
  task automatic send_word(input action_t act, input logic [CODE_W-1:0] code,
                           input bit typed = 1'b0, input tree_link_t want = '0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, code};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (act == ACT_LOAD) begin
      absorb_code(code);
    end else begin
      decodes_sent++;
      decode_tree();
      if (typed) link_q.push_back(want);
      else foreach (forecast_q[i]) link_q.push_back(forecast_q[i]);
      forecast_q.delete();
    end
  endtask

  // wait for the block to drain and go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (link_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_cfg = len;
  endtask

  function automatic void add_row(input row_kind_t k, input logic [CODE_W-1:0] v,
                                  input bit typed = 1'b0, input tree_link_t want = '0);
    row_t r;
    r.kind = k;
    r.val = v;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endfunction

  // one load sequence followed by its decode, well formed or with a flaw
  task automatic run_sequence(input int len);
    int n, cnt, pos;
    flaw_t flaw;
    bit star;
    logic [CODE_W-1:0] hub, code;
    n = len + 2;
    flaw = ($urandom_range(0, 4) == 0) ? flaw_t'($urandom_range(1, 3)) : FLAW_NONE;
    cnt = len;
    if (flaw == FLAW_COUNT) cnt = (len == 0 || $urandom_range(0, 1)) ? len + 1 : len - 1;
    pos = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
    star = ($urandom_range(0, 3) == 0);
    hub = 7'($urandom_range(1, n));
    for (int i = 0; i < cnt; i++) begin
      if (flaw == FLAW_NOISE) code = 7'($urandom_range(0, 127));
      else if (flaw == FLAW_RANGE && i == pos)
        code = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(n + 1, 127));
      else if (star) code = hub;
      else code = 7'($urandom_range(1, n));
      send_word(ACT_LOAD, code);
    end
    send_word(ACT_DECODE, 7'($urandom_range(0, 127)));
    rand_words += cnt + 1;
  endtask

  // receiver with random back-pressure bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result word against the oldest expectation
  always @(posedge clk) begin
    tree_link_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (link_q.size() == 0) begin
        mismatch($sformatf("result word %h last=%b bad=%b with nothing expected",
                           m_tdata, m_tlast, m_tuser));
      end else begin
        want = link_q.pop_front();
        if (m_tdata[6:0] !== want.leaf)
          mismatch($sformatf("edge_first %0d, expected %0d", m_tdata[6:0], want.leaf));
        if (m_tdata[13:7] !== want.nbr)
          mismatch($sformatf("edge_second %0d, expected %0d", m_tdata[13:7], want.nbr));
        if (m_tlast !== want.is_last)
          mismatch($sformatf("last_edge %b, expected %b", m_tlast, want.is_last));
        if (m_tuser !== want.is_bad)
          mismatch($sformatf("bad_input %b, expected %b", m_tuser, want.is_bad));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d words still expected", quiet, link_q.size());
      $display("** prufer_sequence_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    int len, phase;
    wipe_model();
    len_cfg = '0;

    // directed table: reset decode, range and count errors, small trees, length extremes
    add_row(ROW_DECODE, 7'd0, 1'b1, TWO_VERTEX_TREE);
    add_row(ROW_CFG, 7'd1);
    add_row(ROW_LOAD, 7'd3);
    add_row(ROW_DECODE, 7'd0);
    add_row(ROW_LOAD, 7'd0);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_LOAD, 7'd127);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_LOAD, 7'd4);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_LOAD, 7'd1);
    add_row(ROW_LOAD, 7'd2);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_CFG, 7'd2);
    add_row(ROW_LOAD, 7'd4);
    add_row(ROW_LOAD, 7'd4);
    add_row(ROW_DECODE, 7'd0);
    add_row(ROW_LOAD, 7'd64);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_CFG, 7'd63);
    add_row(ROW_DECODE, 7'd0, 1'b1, REJECT_WORD);
    add_row(ROW_CFG, 7'd0);
    add_row(ROW_DECODE, 7'd127, 1'b1, TWO_VERTEX_TREE);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (script[r]) begin
      case (script[r].kind)
        ROW_CFG: begin
          settle();
          write_len(script[r].val[LEN_W-1:0]);
        end
        ROW_LOAD: send_word(ACT_LOAD, script[r].val);
        ROW_DECODE: send_word(ACT_DECODE, script[r].val, script[r].typed, script[r].want);
        default: ;
      endcase
    end

    // random phases: mostly short sequences, one full-size and one oversize length
    phase = 0;
    while (rand_words < RAND_WORDS) begin
      if (phase == 1) len = CODE_SLOTS;
      else if (phase == 3) len = 63;
      else if ($urandom_range(0, 5) == 0) len = $urandom_range(9, 30);
      else len = $urandom_range(0, 8);
      settle();
      write_len(LEN_W'(len));
      idle_on = (phase % 4 != 2);
      if (len > 30) run_sequence(len);
      else repeat ($urandom_range(1, 3)) run_sequence(len);
      phase++;
    end

    // closing stretch at full rate
    idle_on = 1'b0;
    settle();
    write_len(LEN_W'($urandom_range(1, 6)));
    repeat (3) run_sequence(int'(len_cfg));
    settle();

    $display("covered %0d input words, %0d decodes (%0d rejected) over %0d random phases",
             words_sent, decodes_sent, rejects, phase);
    $display("checked %0d result words, %0d mismatches", results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("** prufer_sequence_decoder: PASSED **");
    end else begin
      $display("** prufer_sequence_decoder: FAILED **");
    end
    $finish;
  end

endmodule
